[hw/rtl/negacyclic_ntt_poly_multiply_unit_defines.svh]
// Assertion macros shared by the RTL.
`ifndef NEGACYCLIC_NTT_POLY_MULTIPLY_UNIT_DEFINES_SVH
`define NEGACYCLIC_NTT_POLY_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTTPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nttpm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NTTPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nttpm next-cycle check failed");

`endif

[hw/rtl/nttpm_pkg.sv]
package nttpm_pkg;

	localparam int POLY_SIZE = 1024;
	localparam int LOG_N     = $clog2(POLY_SIZE);
	localparam int STG_W     = $clog2(LOG_N);
	localparam int COEF_BITS = 60;
	localparam int MM_CNT_W  = $clog2(COEF_BITS);
	localparam int IN_W      = ((2 * COEF_BITS + 7) / 8) * 8;
	localparam int OUT_W     = ((COEF_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;

	typedef logic [COEF_BITS-1:0] coef_t;
	typedef logic [LOG_N-1:0]     idx_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PSI     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

	localparam logic [1:0] INV_PSI   = 2'd0;
	localparam logic [1:0] INV_OMEGA = 2'd1;
	localparam logic [1:0] INV_N     = 2'd2;

	localparam coef_t COEF_ONE = coef_t'(1);

	typedef struct packed {
		logic  start;
		coef_t x;
		coef_t y;
	} mm_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RDOUT,
		ST_PSI_W,
		ST_OMG_W,
		ST_NMOD_W,
		ST_EXP_INIT,
		ST_EXP,
		ST_EXP_RW,
		ST_EXP_BW,
		ST_E_RD,
		ST_E_M1,
		ST_E_M1W,
		ST_E_M2W,
		ST_B_CHK,
		ST_B_R2,
		ST_B_W1,
		ST_B_W2,
		ST_N_R1,
		ST_N_R2,
		ST_N_M,
		ST_N_MW,
		ST_N_W2
	} state_t;

	typedef enum logic [3:0] {
		J_RED,
		J_TWA,
		J_FILLF,
		J_NTTA,
		J_TWB,
		J_NTTB,
		J_PMUL,
		J_FILLI,
		J_NTTI,
		J_SCALE,
		J_UNTW
	} job_t;

	function automatic idx_t bitrev(input idx_t v);
		idx_t r;
		for (int k = 0; k < LOG_N; k++) begin
			r[k] = v[LOG_N-1-k];
		end
		return r;
	endfunction

endpackage

[hw/rtl/negacyclic_ntt_poly_multiply_unit.sv]
// Channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata = coef_a, coef_b ; s_tuser = op
// m       | out | m_tvalid/m_tready  | m_tdata = coef_out ; m_tlast = last ; m_tuser = not_ready
// cfg     | in  | cfg_we             | cfg_index, cfg_data (modulus, psi, mode)
//
// The last load of a set starts the compute sequence (unless the modulus is below 2);
// s_tready stays low until it ends. The sequence runs ~12 N modular products for
// reduce/twist/fill/pointwise/scale and 1.5 N log2(N) butterflies, all on the single
// bit-serial modular multiplier. A read beat reads store_a, then loads the output
// register. The output register lets a new beat be taken while a result waits on m_tready.
// Reset clears control and loads the default configuration; the coefficient and twiddle
// memories need no clearing.
`include "negacyclic_ntt_poly_multiply_unit_defines.svh"

module negacyclic_ntt_poly_multiply_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nttpm_pkg::IN_W-1:0]          s_tdata,   // [59:0] coef_a, [119:60] coef_b
	input  logic                                s_tuser,   // [0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nttpm_pkg::OUT_W-1:0]         m_tdata,   // [59:0] coef_out, rest zero
	output logic                                m_tlast,
	output logic                                m_tuser,   // [0] not_ready
	input  logic                                cfg_we,
	input  logic [nttpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nttpm_pkg::COEF_BITS-1:0]     cfg_data
);
	import nttpm_pkg::*;

	// config and sampled config
	coef_t modulus_q, psi_q, qs_q, psis_q;
	logic  mode_q, modes_q;

	// control
	state_t state_q, state_d;
	job_t   job_q, job_d;
	idx_t   load_cnt_q, read_cnt_q, i_q;
	logic   ready_q, zero_q;
	logic [STG_W-1:0] stg_q;
	logic [LOG_N-2:0] m_q;
	logic [1:0] exp_sel_q;
	logic   rd_nr_q, rd_last_q;

	// datapath
	coef_t pw_q, p_q, omega_q, nmod_q, pinv_q, oinv_q, ninv_q;
	coef_t exp_r_q, exp_b_q, exp_e_q;
	coef_t d_q, u_q, w_q, t_q;

	// output register
	logic  out_valid_q, out_last_q, out_nr_q;
	coef_t out_coef_q;

	// memories
	coef_t mem_a [POLY_SIZE];
	coef_t mem_b [POLY_SIZE];
	coef_t mem_tw [POLY_SIZE];
	coef_t a_rdata_q, b_rdata_q, tw_rdata_q;
	logic  a_we, a_re, b_we, b_re, tw_we, tw_re;
	idx_t  a_waddr, a_raddr, b_waddr, b_raddr, tw_waddr, tw_raddr;
	coef_t a_wdata, b_wdata, tw_wdata;

	// shared vector port (store_a or store_b)
	logic  vsel, v_we, v_re;
	idx_t  v_waddr, v_raddr;
	coef_t v_wdata, v_rdata;

	// multiplier
	mm_req_t mm_req;
	logic    mm_busy, mm_done;
	coef_t   mm_prod;

	// control pulses
	logic ld_go, rd_go, job_go, fin, elem_next, brv_next, job_end;
	logic i_inc, pw_ld, p_ld, om_ld, nm_ld, exp_init, r_ld, b_ld, inv_ld, sel_inc;
	logic d_ld, u_ld, t_ld, m_adv, out_ld, cfg_smp;

	// helpers
	idx_t  rev, mx, hmask, k0, k1, widx;
	coef_t root, bf_sum, bf_dif;
	logic [COEF_BITS:0] sum_w, dif_w;
	logic  i_last, bf_last, is_fill, has_mm2;

	nttpm_modmul u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.q     (qs_q),
		.busy  (mm_busy),
		.done  (mm_done),
		.prod  (mm_prod)
	);

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= a_wdata;
		end
		if (a_re) begin
			a_rdata_q <= mem_a[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[b_waddr] <= b_wdata;
		end
		if (b_re) begin
			b_rdata_q <= mem_b[b_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tw_we) begin
			mem_tw[tw_waddr] <= tw_wdata;
		end
		if (tw_re) begin
			tw_rdata_q <= mem_tw[tw_raddr];
		end
	end

	// index and butterfly helpers
	always_comb begin
		vsel    = (job_q == J_TWB) || (job_q == J_NTTB);
		v_rdata = vsel ? b_rdata_q : a_rdata_q;
		rev     = bitrev(i_q);
		i_last  = (i_q == idx_t'(POLY_SIZE - 1));
		mx      = {1'b0, m_q};
		hmask   = idx_t'((1 << stg_q) - 1);
		k0      = idx_t'(((mx >> stg_q) << (stg_q + 1)) | (mx & hmask));
		k1      = k0 | idx_t'(1 << stg_q);
		widx    = idx_t'((mx & hmask) << (LOG_N - 1 - stg_q));
		bf_last = (m_q == '1) && (stg_q == STG_W'(LOG_N - 1));
		sum_w   = {1'b0, u_q} + {1'b0, mm_prod};
		bf_sum  = (sum_w >= {1'b0, qs_q}) ? coef_t'(sum_w - {1'b0, qs_q}) : coef_t'(sum_w);
		dif_w   = (u_q >= t_q) ? {1'b0, u_q} - {1'b0, t_q}
		                       : {1'b0, u_q} + {1'b0, qs_q} - {1'b0, t_q};
		bf_dif  = dif_w[COEF_BITS-1:0];
		is_fill = (job_q == J_FILLF) || (job_q == J_FILLI);
		has_mm2 = (job_q != J_PMUL) && (job_q != J_SCALE);
		unique case (job_q)
			J_FILLF: root = omega_q;
			J_FILLI: root = oinv_q;
			J_UNTW:  root = pinv_q;
			default: root = p_q;
		endcase
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		job_d     = job_q;
		s_tready  = (state_q == ST_IDLE);
		ld_go     = 1'b0;
		rd_go     = 1'b0;
		job_go    = 1'b0;
		fin       = 1'b0;
		elem_next = 1'b0;
		brv_next  = 1'b0;
		job_end   = 1'b0;
		i_inc     = 1'b0;
		pw_ld     = 1'b0;
		p_ld      = 1'b0;
		om_ld     = 1'b0;
		nm_ld     = 1'b0;
		exp_init  = 1'b0;
		r_ld      = 1'b0;
		b_ld      = 1'b0;
		inv_ld    = 1'b0;
		sel_inc   = 1'b0;
		d_ld      = 1'b0;
		u_ld      = 1'b0;
		t_ld      = 1'b0;
		m_adv     = 1'b0;
		out_ld    = 1'b0;
		cfg_smp   = 1'b0;
		mm_req    = '0;
		a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
		b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
		tw_we = 1'b0; tw_waddr = '0; tw_wdata = '0; tw_re = 1'b0; tw_raddr = '0;
		v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_re = 1'b0; v_raddr = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && !s_tuser) begin
					ld_go   = 1'b1;
					a_we    = 1'b1;
					a_waddr = load_cnt_q;
					a_wdata = s_tdata[COEF_BITS-1:0];
					b_we    = 1'b1;
					b_waddr = load_cnt_q;
					b_wdata = s_tdata[2*COEF_BITS-1:COEF_BITS];
					if (load_cnt_q == idx_t'(POLY_SIZE - 1)) begin
						cfg_smp = 1'b1;
						if (modulus_q < coef_t'(2)) begin
							fin = 1'b1;
						end else begin
							job_go = 1'b1;
							job_d  = J_RED;
						end
					end
				end else if (s_tvalid && s_tuser) begin
					rd_go   = 1'b1;
					a_re    = ready_q;
					a_raddr = read_cnt_q;
					state_d = ST_RDOUT;
				end
			end
			ST_RDOUT: begin
				if (!out_valid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PSI_W: begin
				if (mm_done) begin
					p_ld    = 1'b1;
					mm_req  = '{start: 1'b1, x: mm_prod, y: mm_prod};
					state_d = ST_OMG_W;
				end
			end
			ST_OMG_W: begin
				if (mm_done) begin
					om_ld   = 1'b1;
					mm_req  = '{start: 1'b1, x: COEF_ONE, y: coef_t'(POLY_SIZE)};
					state_d = ST_NMOD_W;
				end
			end
			ST_NMOD_W: begin
				if (mm_done) begin
					nm_ld   = 1'b1;
					state_d = ST_EXP_INIT;
				end
			end
			ST_EXP_INIT: begin
				exp_init = 1'b1;
				state_d  = ST_EXP;
			end
			ST_EXP: begin
				if (exp_e_q == '0) begin
					inv_ld = 1'b1;
					if (exp_sel_q == INV_N) begin
						job_go = 1'b1;
						job_d  = J_TWA;
					end else begin
						sel_inc = 1'b1;
						state_d = ST_EXP_INIT;
					end
				end else if (exp_e_q[0]) begin
					mm_req  = '{start: 1'b1, x: exp_r_q, y: exp_b_q};
					state_d = ST_EXP_RW;
				end else begin
					mm_req  = '{start: 1'b1, x: exp_b_q, y: exp_b_q};
					state_d = ST_EXP_BW;
				end
			end
			ST_EXP_RW: begin
				if (mm_done) begin
					r_ld    = 1'b1;
					mm_req  = '{start: 1'b1, x: exp_b_q, y: exp_b_q};
					state_d = ST_EXP_BW;
				end
			end
			ST_EXP_BW: begin
				if (mm_done) begin
					b_ld    = 1'b1;
					state_d = ST_EXP;
				end
			end
			ST_E_RD: begin
				a_re    = 1'b1;
				a_raddr = i_q;
				b_re    = 1'b1;
				b_raddr = i_q;
				state_d = ST_E_M1;
			end
			ST_E_M1: begin
				state_d = ST_E_M1W;
				unique case (job_q)
					J_RED:          mm_req = '{start: 1'b1, x: COEF_ONE, y: a_rdata_q};
					J_TWA, J_UNTW:  mm_req = '{start: 1'b1, x: pw_q, y: a_rdata_q};
					J_TWB:          mm_req = '{start: 1'b1, x: pw_q, y: b_rdata_q};
					J_PMUL:         mm_req = '{start: 1'b1, x: a_rdata_q, y: b_rdata_q};
					J_SCALE:        mm_req = '{start: 1'b1, x: ninv_q, y: a_rdata_q};
					default: begin
						// twiddle fill: store the running power, then step it
						tw_we    = 1'b1;
						tw_waddr = i_q;
						tw_wdata = pw_q;
						mm_req   = '{start: 1'b1, x: pw_q, y: root};
						state_d  = ST_E_M2W;
					end
				endcase
				if (is_fill) begin
					state_d = ST_E_M2W;
				end
			end
			ST_E_M1W: begin
				if (mm_done) begin
					if (job_q == J_TWB) begin
						b_we    = 1'b1;
						b_waddr = i_q;
						b_wdata = mm_prod;
					end else begin
						a_we    = 1'b1;
						a_waddr = i_q;
						a_wdata = mm_prod;
					end
					if (!has_mm2) begin
						elem_next = 1'b1;
					end else if (job_q == J_RED) begin
						mm_req  = '{start: 1'b1, x: COEF_ONE, y: b_rdata_q};
						state_d = ST_E_M2W;
					end else begin
						mm_req  = '{start: 1'b1, x: pw_q, y: root};
						state_d = ST_E_M2W;
					end
				end
			end
			ST_E_M2W: begin
				if (mm_done) begin
					if (job_q == J_RED) begin
						b_we    = 1'b1;
						b_waddr = i_q;
						b_wdata = mm_prod;
					end else begin
						pw_ld = 1'b1;
					end
					elem_next = 1'b1;
				end
			end
			ST_B_CHK: begin
				if (i_q < rev) begin
					v_re    = 1'b1;
					v_raddr = i_q;
					state_d = ST_B_R2;
				end else begin
					brv_next = 1'b1;
				end
			end
			ST_B_R2: begin
				d_ld    = 1'b1;
				v_re    = 1'b1;
				v_raddr = rev;
				state_d = ST_B_W1;
			end
			ST_B_W1: begin
				v_we    = 1'b1;
				v_waddr = i_q;
				v_wdata = v_rdata;
				state_d = ST_B_W2;
			end
			ST_B_W2: begin
				v_we     = 1'b1;
				v_waddr  = rev;
				v_wdata  = d_q;
				brv_next = 1'b1;
			end
			ST_N_R1: begin
				v_re     = 1'b1;
				v_raddr  = k0;
				tw_re    = 1'b1;
				tw_raddr = widx;
				state_d  = ST_N_R2;
			end
			ST_N_R2: begin
				u_ld    = 1'b1;
				v_re    = 1'b1;
				v_raddr = k1;
				state_d = ST_N_M;
			end
			ST_N_M: begin
				mm_req  = '{start: 1'b1, x: v_rdata, y: w_q};
				state_d = ST_N_MW;
			end
			ST_N_MW: begin
				if (mm_done) begin
					t_ld    = 1'b1;
					v_we    = 1'b1;
					v_waddr = k0;
					v_wdata = bf_sum;
					state_d = ST_N_W2;
				end
			end
			ST_N_W2: begin
				v_we    = 1'b1;
				v_waddr = k1;
				v_wdata = bf_dif;
				m_adv   = 1'b1;
				if (bf_last) begin
					job_end = 1'b1;
				end else begin
					state_d = ST_N_R1;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (elem_next) begin
			if (i_last) begin
				job_end = 1'b1;
			end else begin
				i_inc   = 1'b1;
				state_d = ST_E_RD;
			end
		end

		if (brv_next) begin
			if (i_last) begin
				state_d = ST_N_R1;
			end else begin
				i_inc   = 1'b1;
				state_d = ST_B_CHK;
			end
		end

		if (job_end) begin
			unique case (job_q)
				J_RED: begin
					mm_req  = '{start: 1'b1, x: COEF_ONE, y: psis_q};
					state_d = ST_PSI_W;
				end
				J_TWA:   begin job_go = 1'b1; job_d = J_FILLF; end
				J_FILLF: begin job_go = 1'b1; job_d = J_NTTA;  end
				J_NTTA: begin
					if (!modes_q) begin
						fin = 1'b1;
					end else begin
						job_go = 1'b1;
						job_d  = J_TWB;
					end
				end
				J_TWB:   begin job_go = 1'b1; job_d = J_NTTB;  end
				J_NTTB:  begin job_go = 1'b1; job_d = J_PMUL;  end
				J_PMUL:  begin job_go = 1'b1; job_d = J_FILLI; end
				J_FILLI: begin job_go = 1'b1; job_d = J_NTTI;  end
				J_NTTI:  begin job_go = 1'b1; job_d = J_SCALE; end
				J_SCALE: begin job_go = 1'b1; job_d = J_UNTW;  end
				default: fin = 1'b1;
			endcase
		end

		if (job_go) begin
			if (job_d == J_NTTA || job_d == J_NTTB || job_d == J_NTTI) begin
				state_d = ST_B_CHK;
			end else begin
				state_d = ST_E_RD;
			end
		end

		if (fin) begin
			state_d = ST_IDLE;
		end

		// route the shared vector port to store_a or store_b
		if (v_re) begin
			if (vsel) begin
				b_re = 1'b1; b_raddr = v_raddr;
			end else begin
				a_re = 1'b1; a_raddr = v_raddr;
			end
		end
		if (v_we) begin
			if (vsel) begin
				b_we = 1'b1; b_waddr = v_waddr; b_wdata = v_wdata;
			end else begin
				a_we = 1'b1; a_waddr = v_waddr; a_wdata = v_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= J_RED;
			modulus_q   <= coef_t'(12289);
			psi_q       <= coef_t'(7);
			mode_q      <= 1'b1;
			load_cnt_q  <= '0;
			read_cnt_q  <= '0;
			ready_q     <= 1'b0;
			zero_q      <= 1'b0;
			i_q         <= '0;
			stg_q       <= '0;
			m_q         <= '0;
			exp_sel_q   <= INV_PSI;
			rd_nr_q     <= 1'b0;
			rd_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODULUS: modulus_q <= cfg_data;
					CFG_PSI:     psi_q     <= cfg_data;
					CFG_MODE:    mode_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (ld_go) begin
				if (load_cnt_q == '0) begin
					ready_q <= 1'b0;
				end
				load_cnt_q <= (load_cnt_q == idx_t'(POLY_SIZE - 1)) ? '0 : load_cnt_q + 1'b1;
			end
			if (cfg_smp) begin
				zero_q <= (modulus_q < coef_t'(2));
			end
			if (rd_go) begin
				rd_nr_q   <= !ready_q;
				rd_last_q <= ready_q && (read_cnt_q == idx_t'(POLY_SIZE - 1));
				if (ready_q) begin
					read_cnt_q <= read_cnt_q + 1'b1;
				end
			end
			if (fin) begin
				ready_q    <= 1'b1;
				read_cnt_q <= '0;
			end
			if (job_go) begin
				job_q <= job_d;
				i_q   <= '0;
				stg_q <= '0;
				m_q   <= '0;
			end else begin
				if (i_inc) begin
					i_q <= i_q + 1'b1;
				end
				if (m_adv) begin
					m_q <= m_q + 1'b1;
					if (m_q == '1) begin
						stg_q <= stg_q + 1'b1;
					end
				end
			end
			if (nm_ld) begin
				exp_sel_q <= INV_PSI;
			end else if (sel_inc) begin
				exp_sel_q <= exp_sel_q + 1'b1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_smp) begin
			qs_q    <= modulus_q;
			psis_q  <= psi_q;
			modes_q <= mode_q;
		end
		if (job_go) begin
			pw_q <= COEF_ONE;
		end else if (pw_ld) begin
			pw_q <= mm_prod;
		end
		if (p_ld) begin
			p_q <= mm_prod;
		end
		if (om_ld) begin
			omega_q <= mm_prod;
		end
		if (nm_ld) begin
			nmod_q <= mm_prod;
		end
		if (exp_init) begin
			exp_r_q <= COEF_ONE;
			exp_e_q <= qs_q - coef_t'(2);
			unique case (exp_sel_q)
				INV_PSI:   exp_b_q <= p_q;
				INV_OMEGA: exp_b_q <= omega_q;
				default:   exp_b_q <= nmod_q;
			endcase
		end else begin
			if (r_ld) begin
				exp_r_q <= mm_prod;
			end
			if (b_ld) begin
				exp_b_q <= mm_prod;
				exp_e_q <= exp_e_q >> 1;
			end
		end
		if (inv_ld) begin
			unique case (exp_sel_q)
				INV_PSI:   pinv_q <= exp_r_q;
				INV_OMEGA: oinv_q <= exp_r_q;
				default:   ninv_q <= exp_r_q;
			endcase
		end
		if (d_ld) begin
			d_q <= v_rdata;
		end
		if (u_ld) begin
			u_q <= v_rdata;
			w_q <= tw_rdata_q;
		end
		if (t_ld) begin
			t_q <= mm_prod;
		end
		if (out_ld) begin
			out_coef_q <= (rd_nr_q || zero_q) ? '0 : a_rdata_q;
			out_last_q <= rd_last_q;
			out_nr_q   <= rd_nr_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - COEF_BITS){1'b0}}, out_coef_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_nr_q;

	// the multiplier takes a new operand pair only when idle
	`NTTPM_ASSERT_SAME(a_mm_free, clk, arst_n, mm_req.start, !mm_busy)
	// a pending result is never overwritten
	`NTTPM_ASSERT_SAME(a_out_hold, clk, arst_n, out_ld && out_valid_q, m_tready)
	// a finished compute leaves the block ready to read from index zero
	`NTTPM_ASSERT_NEXT(a_fin_ready, clk, arst_n, fin,
		ready_q && (read_cnt_q == '0) && (load_cnt_q == '0))

endmodule

[hw/rtl/nttpm_modmul.sv]
module nttpm_modmul (
	input  logic               clk,
	input  logic               arst_n,
	input  nttpm_pkg::mm_req_t req,
	input  nttpm_pkg::coef_t   q,
	output logic               busy,
	output logic               done,
	output nttpm_pkg::coef_t   prod
);
	import nttpm_pkg::*;

	logic [COEF_BITS:0]  acc_q, dbl, red1, sum, red2, qx;
	coef_t               x_q, y_q, q_q;
	logic [MM_CNT_W-1:0] cnt_q;
	logic                busy_q, done_q;

	// One multiplier bit per cycle, MSB first: double, reduce, add, reduce.
	always_comb begin
		qx   = {1'b0, q_q};
		dbl  = {acc_q[COEF_BITS-1:0], 1'b0};
		red1 = (dbl >= qx) ? dbl - qx : dbl;
		sum  = red1 + (y_q[COEF_BITS-1] ? {1'b0, x_q} : '0);
		red2 = (sum >= qx) ? sum - qx : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MM_CNT_W'(COEF_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
			q_q   <= q;
		end else if (busy_q) begin
			acc_q <= red2;
			y_q   <= {y_q[COEF_BITS-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q[COEF_BITS-1:0];

endmodule

[dv/tb_negacyclic_ntt_poly_multiply_unit.sv]
`timescale 1ns / 1ps

module tb_negacyclic_ntt_poly_multiply_unit;
	import nttpm_pkg::*;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam coef_t COEF_MAX = '1;
	localparam coef_t Q_DEFAULT = coef_t'(12289);
	localparam coef_t PSI_DEFAULT = coef_t'(7);
	localparam int PHASE_ITEMS = 450;   // beats per stall pattern
	localparam int POST_READS = 260;    // reads after the set completes

	// one result beat as the block should send it
	typedef struct packed {
		coef_t coef;
		logic  last;
		logic  not_ready;
	} coef_beat_t;

	// directed row; want is only used where typed is set
	typedef struct packed {
		logic       op;
		coef_t      a;
		coef_t      b;
		logic       typed;
		coef_beat_t want;
	} dir_row_t;

	localparam coef_beat_t NOT_READY_BEAT = '{coef: '0, last: 1'b0, not_ready: 1'b1};
	localparam coef_beat_t NO_BEAT = '0;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // [59:0] coef_a, [119:60] coef_b
	logic              s_tuser;   // [0] op
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // [59:0] coef_out, rest zero
	logic              m_tlast;
	logic              m_tuser;   // [0] not_ready
	logic              cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_BITS-1:0] cfg_data;

	negacyclic_ntt_poly_multiply_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the configuration registers, read by the model at the last load of a set.
	coef_t cur_q;
	coef_t cur_psi;
	logic  cur_mode;

	// Shadow coefficient stores and sequencing state.
	coef_t poly_a [POLY_SIZE];
	coef_t poly_b [POLY_SIZE];
	coef_t twid [POLY_SIZE];
	coef_t work [POLY_SIZE];
	int    load_idx;
	int    read_idx;
	logic  have_result;

	coef_beat_t coef_q [$];   // result beats still owed by the block
	int    mismatches;
	int    items_sent;
	int    src_idle;          // percent of cycles the source holds tvalid low
	int    snk_idle;          // percent of cycles the sink holds tready low

	// Directed opening: reads before any result, extremes of both coefficients,
	// values around the default modulus and alternating bit patterns.
	dir_row_t dir_rows [0:19] = '{
		'{OP_READ, '0, '0, 1'b1, NOT_READY_BEAT},
		'{OP_READ, COEF_MAX, COEF_MAX, 1'b1, NOT_READY_BEAT},
		'{OP_LOAD, '0, '0, 1'b0, NO_BEAT},
		'{OP_LOAD, COEF_MAX, COEF_MAX, 1'b0, NO_BEAT},
		'{OP_READ, '0, '0, 1'b1, NOT_READY_BEAT},
		'{OP_LOAD, COEF_MAX, '0, 1'b0, NO_BEAT},
		'{OP_LOAD, '0, COEF_MAX, 1'b0, NO_BEAT},
		'{OP_LOAD, coef_t'(12288), coef_t'(12288), 1'b0, NO_BEAT},
		'{OP_LOAD, Q_DEFAULT, Q_DEFAULT, 1'b0, NO_BEAT},
		'{OP_LOAD, coef_t'(12290), COEF_ONE, 1'b0, NO_BEAT},
		'{OP_LOAD, 60'haaa_aaaa_aaaa_aaaa, 60'h555_5555_5555_5555, 1'b0, NO_BEAT},
		'{OP_LOAD, 60'h555_5555_5555_5555, 60'haaa_aaaa_aaaa_aaaa, 1'b0, NO_BEAT},
		'{OP_READ, '0, '0, 1'b1, NOT_READY_BEAT},
		'{OP_LOAD, COEF_ONE, COEF_ONE, 1'b0, NO_BEAT},
		'{OP_LOAD, 60'h800_0000_0000_0000, 60'h7ff_ffff_ffff_ffff, 1'b0, NO_BEAT},
		'{OP_LOAD, 60'h7ff_ffff_ffff_ffff, 60'h800_0000_0000_0000, 1'b0, NO_BEAT},
		'{OP_READ, COEF_MAX, '0, 1'b1, NOT_READY_BEAT},
		'{OP_LOAD, coef_t'(12288), COEF_ONE, 1'b0, NO_BEAT},
		'{OP_LOAD, COEF_ONE, coef_t'(12288), 1'b0, NO_BEAT},
		'{OP_READ, '0, COEF_MAX, 1'b1, NOT_READY_BEAT}
	};

	// Stall patterns, stepped through by beat count.
	int    ph_src [3]   = '{20, 83, 0};
	int    ph_snk [3]   = '{83, 20, 0};

	function automatic coef_t mod_mul(input coef_t x, input coef_t y, input coef_t q);
		logic [127:0] p;
		p = {68'd0, x} * {68'd0, y};
		return coef_t'(p % {68'd0, q});
	endfunction

	function automatic coef_t mod_pow(input coef_t base, input coef_t e, input coef_t q);
		coef_t r;
		r = COEF_ONE % q;
		while (e != 0) begin
			if (e[0])
				r = mod_mul(r, base, q);
			base = mod_mul(base, base, q);
			e = e >> 1;
		end
		return r;
	endfunction

	// work[i] *= root^i
	function automatic void twist_work(input coef_t root, input coef_t q);
		coef_t p;
		p = COEF_ONE % q;
		for (int i = 0; i < POLY_SIZE; i++) begin
			work[i] = mod_mul(work[i], p, q);
			p = mod_mul(p, root, q);
		end
	endfunction

	function automatic void fill_twid(input coef_t root, input coef_t q);
		coef_t p;
		p = COEF_ONE % q;
		for (int i = 0; i < POLY_SIZE; i++) begin
			twid[i] = p;
			p = mod_mul(p, root, q);
		end
	endfunction

	// in-place radix-2 transform of work; the input is first put in bit-reversed order
	function automatic void ntt_work(input coef_t q);
		idx_t  rev;
		coef_t u;
		coef_t t;
		logic [COEF_BITS:0] s;
		int    half;
		int    step;
		for (int i = 0; i < POLY_SIZE; i++) begin
			for (int k = 0; k < LOG_N; k++)
				rev[k] = i[LOG_N-1-k];
			if (i < int'(rev)) begin
				t = work[i];
				work[i] = work[rev];
				work[rev] = t;
			end
		end
		for (int len = 2; len <= POLY_SIZE; len <<= 1) begin
			half = len / 2;
			step = POLY_SIZE / len;
			for (int base = 0; base + len <= POLY_SIZE; base += len) begin
				for (int j = 0; j < half; j++) begin
					u = work[base + j];
					t = mod_mul(work[base + j + half], twid[(j * step) % POLY_SIZE], q);
					s = {1'b0, u} + {1'b0, t};
					work[base + j] = (s >= {1'b0, q}) ? coef_t'(s - {1'b0, q})
					                                  : coef_t'(s);
					work[base + j + half] = (u >= t) ? u - t : u + q - t;
				end
			end
		end
	endfunction

	// Result of a full set, left in poly_a.
	function automatic void multiply_set();
		coef_t q;
		coef_t p;
		coef_t omega;
		coef_t inv_psi;
		coef_t inv_omega;
		coef_t inv_n;
		q = cur_q;
		if (q < 2) begin
			// degenerate modulus: everything collapses to zero
			for (int i = 0; i < POLY_SIZE; i++)
				poly_a[i] = '0;
			return;
		end
		for (int i = 0; i < POLY_SIZE; i++) begin
			poly_a[i] = poly_a[i] % q;
			poly_b[i] = poly_b[i] % q;
		end
		p = cur_psi % q;
		omega = mod_mul(p, p, q);
		inv_psi = mod_pow(p, q - 2, q);
		inv_omega = mod_pow(omega, q - 2, q);
		inv_n = mod_pow(coef_t'(POLY_SIZE) % q, q - 2, q);

		work = poly_a;
		twist_work(p, q);
		fill_twid(omega, q);
		ntt_work(q);
		poly_a = work;
		if (!cur_mode)
			return;

		work = poly_b;
		twist_work(p, q);
		ntt_work(q);
		for (int i = 0; i < POLY_SIZE; i++)
			work[i] = mod_mul(poly_a[i], work[i], q);
		fill_twid(inv_omega, q);
		ntt_work(q);
		for (int i = 0; i < POLY_SIZE; i++)
			work[i] = mod_mul(work[i], inv_n, q);
		twist_work(inv_psi, q);
		poly_a = work;
	endfunction

	// Advance the shadow state by one accepted input beat.
	function automatic void predict_beat(input logic op, input coef_t a, input coef_t b);
		coef_beat_t e;
		if (op == OP_LOAD) begin
			// first load of a new set drops the old result
			if (load_idx == 0)
				have_result = 1'b0;
			poly_a[load_idx] = a;
			poly_b[load_idx] = b;
			load_idx++;
			if (load_idx == POLY_SIZE) begin
				multiply_set();
				load_idx = 0;
				read_idx = 0;
				have_result = 1'b1;
			end
		end else if (!have_result) begin
			coef_q.push_back(NOT_READY_BEAT);
		end else begin
			e.coef = poly_a[read_idx];
			e.last = (read_idx == POLY_SIZE - 1);
			e.not_ready = 1'b0;
			coef_q.push_back(e);
			read_idx = (read_idx + 1) % POLY_SIZE;   // reading past the end wraps
		end
	endfunction

	// Random coefficient biased toward the edges of the current modulus and of the coefficient range.
	function automatic coef_t rand_coef();
		coef_t r;
		r = coef_t'({$urandom, $urandom});
		case ($urandom_range(3))
			0: return r;
			1: return (cur_q != 0) ? r % cur_q : r;
			2: return (cur_q >= 4) ? cur_q - coef_t'($urandom_range(1, 3)) : cur_q;
			default: return COEF_MAX - coef_t'($urandom_range(3));
		endcase
	endfunction

	// Called and returns at a falling edge.
	task automatic send_beat(input logic op, input coef_t a, input coef_t b,
			input logic typed, input coef_beat_t want);
		int ph;
		ph = (items_sent < PHASE_ITEMS) ? 0 : (items_sent < 2 * PHASE_ITEMS) ? 1 : 2;
		src_idle = ph_src[ph];
		snk_idle = ph_snk[ph];
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (typed)
			coef_q.push_back(want);
		else
			predict_beat(op, a, b);
		@(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MODULUS: cur_q = val;
			CFG_PSI: cur_psi = val;
			CFG_MODE: cur_mode = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	// Sink stall pattern
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle);

	// Result checker
	always @(posedge clk) begin : check_out
		coef_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (coef_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: coef %h last %b not_ready %b",
						m_tdata, m_tlast, m_tuser);
			end else begin
				e = coef_q.pop_front();
				if (m_tdata !== OUT_W'(e.coef) || m_tlast !== e.last
						|| m_tuser !== e.not_ready) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp coef %h last %b nr %b, got coef %h last %b nr %b",
							e.coef, e.last, e.not_ready, m_tdata, m_tlast, m_tuser);
				end
			end
		end
	end

	initial begin : stim
		int loads_sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		cfg_we = 1'b0;
		cfg_index = CFG_MODULUS;
		cfg_data = '0;
		cur_q = Q_DEFAULT;
		cur_psi = PSI_DEFAULT;
		cur_mode = 1'b1;
		load_idx = 0;
		read_idx = 0;
		have_result = 1'b0;
		mismatches = 0;
		items_sent = 0;
		src_idle = 0;
		snk_idle = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a real prime with the full product
		cfg_write(CFG_MODULUS, Q_DEFAULT);
		cfg_write(CFG_PSI, PSI_DEFAULT);
		cfg_write(CFG_MODE, COEF_ONE);
		cfg_we <= 1'b0;
		loads_sent = 0;

		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
				dir_rows[i].typed, dir_rows[i].want);
			if (dir_rows[i].op == OP_LOAD)
				loads_sent++;
		end

		// rest of the set, with the odd read thrown in while loading
		while (loads_sent < POLY_SIZE) begin
			if ($urandom_range(99) < 4) begin
				send_beat(OP_READ, rand_coef(), rand_coef(), 1'b0, NO_BEAT);
			end else begin
				send_beat(OP_LOAD, rand_coef(), rand_coef(), 1'b0, NO_BEAT);
				loads_sent++;
			end
		end

		// read the front of the result
		for (int i = 0; i < POST_READS; i++)
			send_beat(OP_READ, rand_coef(), rand_coef(), 1'b0, NO_BEAT);

		// a new partial set discards the result; reads then report not ready
		for (int i = 0; i < 8; i++)
			send_beat(OP_LOAD, rand_coef(), rand_coef(), 1'b0, NO_BEAT);
		for (int i = 0; i < 4; i++)
			send_beat(OP_READ, rand_coef(), rand_coef(), 1'b0, NO_BEAT);
		s_tvalid <= 1'b0;

		while (coef_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && coef_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
